>>> src/two_link_leg_inverse_kinematics_macros.svh
// Assertion macros shared by the leg inverse kinematics design.
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IKL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ikl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IKL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ikl assertion failed");

`endif

>>> src/ikl_pkg.sv
// Package with types, constants and helpers of the leg inverse kinematics block.
package ikl_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS = 29;
   localparam int DIV_STEPS = 29;
   localparam int RAD_W = 2 * SQRT_STEPS;
   localparam int REM_W = SQRT_STEPS + 2;
   localparam int DEN_W = 34;
   localparam int CW = 36;
   localparam int ZW = 26;
   localparam int ATAN_N = 32;
   localparam int IDX_W = $clog2(ATAN_N);

   localparam int ST_RES = 0;
   localparam int ST_SQ = 1;
   localparam int ST_SUM = 2;
   localparam int ST_SQA = 3;
   localparam int ST_NUM = ST_SQA + SQRT_STEPS;
   localparam int ST_CMP = ST_NUM + 1;
   localparam int ST_DIV = ST_CMP + 1;
   localparam int ST_AC = ST_DIV + DIV_STEPS;
   localparam int ST_AC2 = ST_AC + 1;
   localparam int ST_RAD = ST_AC2 + 1;
   localparam int ST_SQB = ST_RAD + 1;
   localparam int ST_COR = ST_SQB + SQRT_STEPS;
   localparam int ST_ANG = ST_COR + CORDIC_STAGES;
   localparam int NSTAGE = ST_ANG + 1;

   localparam logic [DIV_STEPS-1:0] Q28_ONE = DIV_STEPS'(1) << 28;
   localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);

   localparam int ATAN_TAB [ATAN_N] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   localparam logic OP_ABS = 1'b0;
   localparam logic OP_REL = 1'b1;

   localparam logic [1:0] REG_UPPER = 2'd0;
   localparam logic [1:0] REG_LOWER = 2'd1;
   localparam logic [1:0] REG_HIP_X = 2'd2;
   localparam logic [1:0] REG_HIP_Y = 2'd3;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [SQRT_STEPS-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [DEN_W:0] r;
      logic [DIV_STEPS-1:0] q;
   } div_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [32:0] dxsq;
      logic [32:0] dysq;
      logic [29:0] l1sq;
      logic [29:0] l2sq;
      logic [33:0] lsq;
      logic signed [35:0] nbase;
      logic signed [35:0] num;
      logic [16:0] len;
      logic [DEN_W-1:0] den;
      logic sat;
      logic cneg;
      logic flag;
      logic [DIV_STEPS-1:0] ac;
      logic [RAD_W-1:0] rad;
      logic signed [ZW-1:0] phi;
      logic signed [ZW-1:0] psi;
   } side_type;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      if (v > 17'sd32767) begin
         return 16'sh7fff;
      end else if (v < -17'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] out_angle(input logic signed [ZW:0] v);
      logic signed [ZW:0] t;
      logic signed [ZW-10:0] a;
      t = v + (ZW+1)'(512);
      a = (ZW-9)'(t >>> 10);
      if (a > (ZW-9)'(17280)) begin
         return 16'sd17280;
      end else if (a < -(ZW-9)'(5760)) begin
         return -16'sd5760;
      end
      return a[15:0];
   endfunction

endpackage

>>> src/ikl_req_if.sv
// Input channel interface carrying a foot target word.
interface ikl_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic signed [15:0] target_x;
   logic signed [15:0] target_y;
   logic signed [15:0] current_x;
   logic signed [15:0] current_y;

   modport source (output valid, opcode, target_x, target_y, current_x, current_y,
                   input ready);
   modport sink (input valid, opcode, target_x, target_y, current_x, current_y,
                 output ready);
endinterface

>>> src/ikl_rsp_if.sv
// Result channel interface carrying the joint solution word.
interface ikl_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] resolved_x;
   logic signed [15:0] resolved_y;
   logic [15:0] leg_length;
   logic signed [15:0] joint_angle_one;
   logic signed [15:0] joint_angle_two;
   logic unreachable;

   modport source (output valid, resolved_x, resolved_y, leg_length, joint_angle_one,
                   joint_angle_two, unreachable, input ready);
   modport sink (input valid, resolved_x, resolved_y, leg_length, joint_angle_one,
                 joint_angle_two, unreachable, output ready);
endinterface

>>> src/ikl_sqrt_cell.sv
// One digit cell of the pipelined restoring integer square root.
module ikl_sqrt_cell (
   input  logic clock,
   input  logic en,
   input  ikl_pkg::sqrt_type d_in,
   output ikl_pkg::sqrt_type d_ff
);
   ikl_pkg::sqrt_type d_in_next;
   logic [ikl_pkg::REM_W-1:0] cur;
   logic [ikl_pkg::REM_W-1:0] trial;

   always_comb begin
      cur = {d_in.rem[ikl_pkg::SQRT_STEPS-1:0], d_in.rad[ikl_pkg::RAD_W-1 -: 2]};
      trial = {d_in.root, 2'b01};
      d_in_next.rad = {d_in.rad[ikl_pkg::RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         d_in_next.rem = cur - trial;
         d_in_next.root = {d_in.root[ikl_pkg::SQRT_STEPS-2:0], 1'b1};
      end else begin
         d_in_next.rem = cur;
         d_in_next.root = {d_in.root[ikl_pkg::SQRT_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end
endmodule

>>> src/ikl_div_cell.sv
// One quotient bit cell of the pipelined restoring divider.
module ikl_div_cell (
   input  logic clock,
   input  logic en,
   input  logic [ikl_pkg::DEN_W-1:0] den,
   input  ikl_pkg::div_type d_in,
   output ikl_pkg::div_type d_ff
);
   ikl_pkg::div_type d_in_next;
   logic [ikl_pkg::DEN_W:0] t;

   always_comb begin
      if (d_in.r >= {1'b0, den}) begin
         t = d_in.r - {1'b0, den};
         d_in_next.q = {d_in.q[ikl_pkg::DIV_STEPS-2:0], 1'b1};
      end else begin
         t = d_in.r;
         d_in_next.q = {d_in.q[ikl_pkg::DIV_STEPS-2:0], 1'b0};
      end
      d_in_next.r = {t[ikl_pkg::DEN_W-1:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end
endmodule

>>> src/ikl_cordic_cell.sv
// One vectoring CORDIC rotation cell.
module ikl_cordic_cell (
   input  logic clock,
   input  logic en,
   input  logic [ikl_pkg::IDX_W-1:0] idx,
   input  ikl_pkg::cordic_type d_in,
   output ikl_pkg::cordic_type d_ff
);
   ikl_pkg::cordic_type d_in_next;
   logic signed [ikl_pkg::CW-1:0] xs;
   logic signed [ikl_pkg::CW-1:0] ys;
   logic signed [ikl_pkg::ZW-1:0] ang;

   always_comb begin
      xs = d_in.x >>> idx;
      ys = d_in.y >>> idx;
      ang = ikl_pkg::ZW'(ikl_pkg::ATAN_TAB[idx]);
      d_in_next = d_in;
      if (d_in.y > 0) begin
         d_in_next.x = d_in.x + ys;
         d_in_next.y = d_in.y - xs;
         d_in_next.z = d_in.z + ang;
      end else if (d_in.y < 0) begin
         d_in_next.x = d_in.x - ys;
         d_in_next.y = d_in.y + xs;
         d_in_next.z = d_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end
endmodule

>>> src/two_link_leg_inverse_kinematics.sv
// Top level of the two-link leg inverse kinematics pipeline.
// Usage: a word on req_chan holds a foot target, absolute or relative to the
// present foot position. Each accepted word yields one word on rsp_chan with
// the target used, the hip-to-foot length, both joint angles and a flag.
// The block is a row of cells that all advance together: two square root
// rows of 29 digit cells, a divider row of 29 quotient cells and two CORDIC
// rows of 16 rotation cells, with a few arithmetic stages around them.
// Each accepted word passes through every stage of that row and then the
// output register. A new word is accepted in every cycle the row advances.
// The link lengths and hip offsets live in four 32-bit registers on the
// csr_ port at byte addresses 0, 4, 8 and 12; write them only while idle.
// Reset is synchronous and clears all words in flight and restores the
// registers to their defaults. When the receiver stalls, the finished word
// stays on rsp_chan; words keep moving until one reaches the last cell, and
// only then does the row stop and req_chan drop ready.
`include "two_link_leg_inverse_kinematics_macros.svh"
module two_link_leg_inverse_kinematics (
   input  logic clock,
   input  logic reset,
   ikl_req_if.sink req_chan,
   ikl_rsp_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int LAST = ikl_pkg::ST_ANG;

   logic [14:0] upper_link_length_ff;
   logic [14:0] lower_link_length_ff;
   logic signed [15:0] hip_offset_x_ff;
   logic signed [15:0] hip_offset_y_ff;
   logic [1:0] csr_index;
   logic csr_write;

   logic advance;
   logic [ikl_pkg::NSTAGE-1:0] vld_ff;
   ikl_pkg::side_type sb_ff [ikl_pkg::NSTAGE];
   ikl_pkg::side_type sb_in [ikl_pkg::NSTAGE];

   ikl_pkg::sqrt_type sqa_d [ikl_pkg::SQRT_STEPS];
   ikl_pkg::sqrt_type sqa_q [ikl_pkg::SQRT_STEPS];
   ikl_pkg::sqrt_type sqb_d [ikl_pkg::SQRT_STEPS];
   ikl_pkg::sqrt_type sqb_q [ikl_pkg::SQRT_STEPS];
   ikl_pkg::div_type div_d [ikl_pkg::DIV_STEPS];
   ikl_pkg::div_type div_q [ikl_pkg::DIV_STEPS];
   ikl_pkg::cordic_type phi_d [ikl_pkg::CORDIC_STAGES];
   ikl_pkg::cordic_type phi_q [ikl_pkg::CORDIC_STAGES];
   ikl_pkg::cordic_type psi_d [ikl_pkg::CORDIC_STAGES];
   ikl_pkg::cordic_type psi_q [ikl_pkg::CORDIC_STAGES];

   logic rsp_valid_ff;
   logic signed [15:0] resolved_x_ff;
   logic signed [15:0] resolved_y_ff;
   logic [15:0] leg_length_ff;
   logic signed [15:0] joint_angle_one_ff;
   logic signed [15:0] joint_angle_two_ff;
   logic unreachable_ff;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[3:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_link_length_ff <= 15'd2400;
         lower_link_length_ff <= 15'd2400;
         hip_offset_x_ff <= 16'sd0;
         hip_offset_y_ff <= 16'sd0;
      end else if (csr_write) begin
         case (csr_index)
            ikl_pkg::REG_UPPER: upper_link_length_ff <= csr_pwdata[14:0];
            ikl_pkg::REG_LOWER: lower_link_length_ff <= csr_pwdata[14:0];
            ikl_pkg::REG_HIP_X: hip_offset_x_ff <= csr_pwdata[15:0];
            ikl_pkg::REG_HIP_Y: hip_offset_y_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ikl_pkg::REG_UPPER: csr_prdata = {17'd0, upper_link_length_ff};
         ikl_pkg::REG_LOWER: csr_prdata = {17'd0, lower_link_length_ff};
         ikl_pkg::REG_HIP_X: csr_prdata = 32'(hip_offset_x_ff);
         ikl_pkg::REG_HIP_Y: csr_prdata = 32'(hip_offset_y_ff);
         default: csr_prdata = 32'd0;
      endcase
   end

   // The whole row moves unless a finished word would overwrite a stalled one.
   assign advance = !(vld_ff[LAST] && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[ikl_pkg::NSTAGE-2:0], req_chan.valid};
      end
   end

   // Per-stage side data and the arithmetic done between the cell rows.
   always_comb begin
      logic signed [16:0] sum_x;
      logic signed [16:0] sum_y;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic signed [33:0] psq_x;
      logic signed [33:0] psq_y;
      logic [31:0] denh;
      logic signed [35:0] num;
      logic signed [35:0] dens;
      sum_x = 17'(req_chan.current_x) + 17'(req_chan.target_x);
      sum_y = 17'(req_chan.current_y) + 17'(req_chan.target_y);
      rx = (req_chan.opcode == ikl_pkg::OP_REL) ? ikl_pkg::sat16(sum_x) : req_chan.target_x;
      ry = (req_chan.opcode == ikl_pkg::OP_REL) ? ikl_pkg::sat16(sum_y) : req_chan.target_y;
      sb_in[0] = sb_ff[0];
      for (int i = 1; i < ikl_pkg::NSTAGE; i++) begin
         sb_in[i] = sb_ff[i-1];
      end
      sb_in[ikl_pkg::ST_RES].rx = rx;
      sb_in[ikl_pkg::ST_RES].ry = ry;
      sb_in[ikl_pkg::ST_RES].dx = 17'(hip_offset_x_ff) + 17'(rx);
      sb_in[ikl_pkg::ST_RES].dy = 17'(hip_offset_y_ff) - 17'(ry);

      psq_x = 34'(sb_ff[ikl_pkg::ST_SQ-1].dx) * 34'(sb_ff[ikl_pkg::ST_SQ-1].dx);
      psq_y = 34'(sb_ff[ikl_pkg::ST_SQ-1].dy) * 34'(sb_ff[ikl_pkg::ST_SQ-1].dy);
      sb_in[ikl_pkg::ST_SQ].dxsq = psq_x[32:0];
      sb_in[ikl_pkg::ST_SQ].dysq = psq_y[32:0];
      sb_in[ikl_pkg::ST_SQ].l1sq = 30'(upper_link_length_ff) * 30'(upper_link_length_ff);
      sb_in[ikl_pkg::ST_SQ].l2sq = 30'(lower_link_length_ff) * 30'(lower_link_length_ff);

      sb_in[ikl_pkg::ST_SUM].lsq = 34'(sb_ff[ikl_pkg::ST_SUM-1].dxsq)
                                 + 34'(sb_ff[ikl_pkg::ST_SUM-1].dysq);
      sb_in[ikl_pkg::ST_SUM].nbase = $signed({6'd0, sb_ff[ikl_pkg::ST_SUM-1].l1sq})
                                   - $signed({6'd0, sb_ff[ikl_pkg::ST_SUM-1].l2sq});

      sb_in[ikl_pkg::ST_NUM].len = sqa_q[ikl_pkg::SQRT_STEPS-1].root[16:0];
      sb_in[ikl_pkg::ST_NUM].num = sb_ff[ikl_pkg::ST_NUM-1].nbase
                                 + $signed({2'd0, sb_ff[ikl_pkg::ST_NUM-1].lsq});

      denh = 32'(upper_link_length_ff) * 32'(sb_ff[ikl_pkg::ST_CMP-1].len);
      num = sb_ff[ikl_pkg::ST_CMP-1].num;
      dens = $signed({3'd0, denh, 1'b0});
      sb_in[ikl_pkg::ST_CMP].den = {1'b0, denh, 1'b0};
      if (denh == 32'd0) begin
         sb_in[ikl_pkg::ST_CMP].sat = 1'b1;
         sb_in[ikl_pkg::ST_CMP].flag = 1'b1;
         sb_in[ikl_pkg::ST_CMP].cneg = 1'b0;
      end else if (num > dens) begin
         sb_in[ikl_pkg::ST_CMP].sat = 1'b1;
         sb_in[ikl_pkg::ST_CMP].flag = 1'b1;
         sb_in[ikl_pkg::ST_CMP].cneg = 1'b0;
      end else if (num < -dens) begin
         sb_in[ikl_pkg::ST_CMP].sat = 1'b1;
         sb_in[ikl_pkg::ST_CMP].flag = 1'b1;
         sb_in[ikl_pkg::ST_CMP].cneg = 1'b1;
      end else begin
         sb_in[ikl_pkg::ST_CMP].sat = 1'b0;
         sb_in[ikl_pkg::ST_CMP].flag = 1'b0;
         sb_in[ikl_pkg::ST_CMP].cneg = num < 0;
      end
      sb_in[ikl_pkg::ST_CMP].num = (num < 0) ? -num : num;

      sb_in[ikl_pkg::ST_AC].ac = sb_ff[ikl_pkg::ST_AC-1].sat ? ikl_pkg::Q28_ONE
                                 : div_q[ikl_pkg::DIV_STEPS-1].q;
      // A negative ratio that rounds to zero is plain zero and is not mirrored.
      sb_in[ikl_pkg::ST_AC].cneg = sb_ff[ikl_pkg::ST_AC-1].cneg
                                 && (sb_ff[ikl_pkg::ST_AC-1].sat
                                     || div_q[ikl_pkg::DIV_STEPS-1].q != '0);
      sb_in[ikl_pkg::ST_AC2].rad = ikl_pkg::RAD_W'(sb_ff[ikl_pkg::ST_AC2-1].ac)
                                 * ikl_pkg::RAD_W'(sb_ff[ikl_pkg::ST_AC2-1].ac);
      sb_in[ikl_pkg::ST_RAD].rad = (ikl_pkg::RAD_W'(1) << 56) - sb_ff[ikl_pkg::ST_RAD-1].rad;

      sb_in[ikl_pkg::ST_ANG].phi = sb_ff[ikl_pkg::ST_ANG-1].cneg
                                 ? ikl_pkg::DEG_180 - phi_q[ikl_pkg::CORDIC_STAGES-1].z
                                 : phi_q[ikl_pkg::CORDIC_STAGES-1].z;
      sb_in[ikl_pkg::ST_ANG].psi = psi_q[ikl_pkg::CORDIC_STAGES-1].z;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff <= sb_in;
      end
   end

   // Cell row inputs.
   always_comb begin
      logic [16:0] ady;
      ady = sb_ff[ikl_pkg::ST_COR-1].dy[16] ? 17'(-sb_ff[ikl_pkg::ST_COR-1].dy)
            : 17'(sb_ff[ikl_pkg::ST_COR-1].dy);
      sqa_d[0].rad = ikl_pkg::RAD_W'(sb_ff[ikl_pkg::ST_SQA-1].lsq);
      sqa_d[0].rem = '0;
      sqa_d[0].root = '0;
      sqb_d[0].rad = sb_ff[ikl_pkg::ST_SQB-1].rad;
      sqb_d[0].rem = '0;
      sqb_d[0].root = '0;
      for (int k = 1; k < ikl_pkg::SQRT_STEPS; k++) begin
         sqa_d[k] = sqa_q[k-1];
         sqb_d[k] = sqb_q[k-1];
      end
      div_d[0].r = sb_ff[ikl_pkg::ST_DIV-1].sat ? '0
                   : (ikl_pkg::DEN_W+1)'(sb_ff[ikl_pkg::ST_DIV-1].num[ikl_pkg::DEN_W-1:0]);
      div_d[0].q = '0;
      for (int k = 1; k < ikl_pkg::DIV_STEPS; k++) begin
         div_d[k] = div_q[k-1];
      end
      phi_d[0].x = $signed(ikl_pkg::CW'(sb_ff[ikl_pkg::ST_COR-1].ac));
      phi_d[0].y = $signed(ikl_pkg::CW'(sqb_q[ikl_pkg::SQRT_STEPS-1].root));
      phi_d[0].z = '0;
      psi_d[0].x = $signed(ikl_pkg::CW'({ady, 14'd0}));
      psi_d[0].y = ikl_pkg::CW'($signed({sb_ff[ikl_pkg::ST_COR-1].dx, 14'd0}));
      psi_d[0].z = '0;
      for (int k = 1; k < ikl_pkg::CORDIC_STAGES; k++) begin
         phi_d[k] = phi_q[k-1];
         psi_d[k] = psi_q[k-1];
      end
   end

   for (genvar k = 0; k < ikl_pkg::SQRT_STEPS; k++) begin : g_sqrt
      ikl_sqrt_cell u_sqa (.clock(clock), .en(advance), .d_in(sqa_d[k]), .d_ff(sqa_q[k]));
      ikl_sqrt_cell u_sqb (.clock(clock), .en(advance), .d_in(sqb_d[k]), .d_ff(sqb_q[k]));
   end

   for (genvar k = 0; k < ikl_pkg::DIV_STEPS; k++) begin : g_div
      ikl_div_cell u_div (
         .clock(clock),
         .en(advance),
         .den(sb_ff[ikl_pkg::ST_DIV+k-1].den),
         .d_in(div_d[k]),
         .d_ff(div_q[k])
      );
   end

   for (genvar k = 0; k < ikl_pkg::CORDIC_STAGES; k++) begin : g_cordic
      ikl_cordic_cell u_phi (
         .clock(clock),
         .en(advance),
         .idx(ikl_pkg::IDX_W'(k)),
         .d_in(phi_d[k]),
         .d_ff(phi_q[k])
      );
      ikl_cordic_cell u_psi (
         .clock(clock),
         .en(advance),
         .idx(ikl_pkg::IDX_W'(k)),
         .d_in(psi_d[k]),
         .d_ff(psi_q[k])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (vld_ff[LAST] && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[LAST] && advance) begin
         resolved_x_ff <= sb_ff[LAST].rx;
         resolved_y_ff <= sb_ff[LAST].ry;
         leg_length_ff <= sb_ff[LAST].len[16] ? 16'hffff : sb_ff[LAST].len[15:0];
         joint_angle_one_ff <= ikl_pkg::out_angle(
            (ikl_pkg::ZW+1)'(sb_ff[LAST].phi) - (ikl_pkg::ZW+1)'(sb_ff[LAST].psi));
         joint_angle_two_ff <= ikl_pkg::out_angle(
            (ikl_pkg::ZW+1)'(sb_ff[LAST].phi) + (ikl_pkg::ZW+1)'(sb_ff[LAST].psi));
         unreachable_ff <= sb_ff[LAST].flag;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.resolved_x = resolved_x_ff;
   assign rsp_chan.resolved_y = resolved_y_ff;
   assign rsp_chan.leg_length = leg_length_ff;
   assign rsp_chan.joint_angle_one = joint_angle_one_ff;
   assign rsp_chan.joint_angle_two = joint_angle_two_ff;
   assign rsp_chan.unreachable = unreachable_ff;

   `IKL_ASSERT_NEXT(a_last_held, clock, reset, vld_ff[LAST] && !advance, vld_ff[LAST])
   `IKL_ASSERT_NEXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[0])
   `IKL_ASSERT_SAME(a_zero_len_flag, clock, reset,
      rsp_chan.valid && rsp_chan.leg_length == 16'd0, rsp_chan.unreachable)
   `IKL_ASSERT_SAME(a_angle_range, clock, reset, rsp_chan.valid,
      rsp_chan.joint_angle_one >= -16'sd5760 && rsp_chan.joint_angle_one <= 16'sd17280)
endmodule
